FILE: rtl/nrrd_pkg.sv
// ----------------------------------------------------------------------------
// Newton-Raphson reciprocal divider package
// Shared constants and the payload types passed between pipeline sections.
// ----------------------------------------------------------------------------
package nrrd_pkg;

    localparam logic [16:0] QUOT_MAX    = 17'h1ffff;
    localparam int          SEED_DEPTH  = 257;
    localparam int          SEED_BASE   = 32'h101;
    localparam int          SEED_ONE    = 32'h40000;
    localparam int          SEED_OFFSET = 32'h100;

    typedef struct packed {
        logic        ovf;
        logic [16:0] num;
        logic [15:0] divisor;
    } nrrd_norm_t;

    typedef struct packed {
        logic        ovf;
        logic [16:0] num;
        logic [23:0] recip;
    } nrrd_recip_t;

endpackage

FILE: rtl/nrrd_norm.sv
// ----------------------------------------------------------------------------
// Operand normalisation
// Detects overflow and shifts both operands left until the divisor's top bit
// is set, using a four-step binary shifter.
// ----------------------------------------------------------------------------
module nrrd_norm
    import nrrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] numerator,
    input  logic [15:0] denominator,
    output logic        out_valid,
    output nrrd_norm_t  out_word
);

    logic       valid_reg;
    nrrd_norm_t word_reg;
    nrrd_norm_t word_next;

    logic [15:0] den0, den1, den2, den3, den4;
    logic [16:0] num0, num1, num2, num3, num4;

    always_comb
    begin
        den0 = denominator;
        num0 = {1'b0, numerator};
        den1 = (den0[15:8] == 8'd0) ? {den0[7:0], 8'd0} : den0;
        num1 = (den0[15:8] == 8'd0) ? {num0[8:0], 8'd0} : num0;
        den2 = (den1[15:12] == 4'd0) ? {den1[11:0], 4'd0} : den1;
        num2 = (den1[15:12] == 4'd0) ? {num1[12:0], 4'd0} : num1;
        den3 = (den2[15:14] == 2'd0) ? {den2[13:0], 2'd0} : den2;
        num3 = (den2[15:14] == 2'd0) ? {num2[14:0], 2'd0} : num2;
        den4 = (den3[15] == 1'b0) ? {den3[14:0], 1'b0} : den3;
        num4 = (den3[15] == 1'b0) ? {num3[15:0], 1'b0} : num3;

        word_next.ovf     = ({denominator, 1'b0} <= {1'b0, numerator});
        word_next.num     = num4;
        word_next.divisor = den4 | 16'h8000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: rtl/nrrd_refine.sv
// ----------------------------------------------------------------------------
// Reciprocal seed and refinement
// Looks up the reciprocal seed, then performs one Newton-Raphson step over
// three register stages, one multiplication in each but the seed stage.
// ----------------------------------------------------------------------------
module nrrd_refine
    import nrrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  nrrd_norm_t  in_word,
    output logic        out_valid,
    output nrrd_recip_t out_word
);

    logic [7:0] seed_tab [SEED_DEPTH];

    for (genvar g = 0; g < SEED_DEPTH; g++)
    begin : g_seed
        localparam int SEED = ((SEED_ONE / (g + SEED_OFFSET)) + 1) / 2 - SEED_BASE;
        assign seed_tab[g] = (SEED < 0) ? 8'd0 : SEED[7:0];
    end

    // Seed stage.
    logic        s2_valid_reg;
    logic        s2_ovf_reg;
    logic [16:0] s2_num_reg;
    logic [15:0] s2_div_reg;
    logic [9:0]  s2_x_reg;
    logic [9:0]  s2_x_next;
    logic [15:0] idx_sum;
    logic [8:0]  idx;

    always_comb
    begin
        idx_sum   = {1'b0, in_word.divisor[14:0]} + 16'h0040;
        idx       = idx_sum[15:7];
        s2_x_next = 10'(SEED_BASE) + {2'b00, seed_tab[idx]};
    end

    // Correction stage.
    logic               s3_valid_reg;
    logic               s3_ovf_reg;
    logic [16:0]        s3_num_reg;
    logic [9:0]         s3_x_reg;
    logic signed [19:0] s3_e_reg;
    logic signed [19:0] s3_e_next;
    logic [25:0]        dx_prod;
    logic signed [26:0] corr;
    logic signed [26:0] corr_sh;

    always_comb
    begin
        dx_prod   = s2_div_reg * {6'd0, s2_x_reg};
        corr      = 27'sd128 - $signed({1'b0, dx_prod});
        corr_sh   = corr >>> 8;
        s3_e_next = $signed(corr_sh[19:0]) + 20'sd131072;
    end

    // Reciprocal stage.
    logic               s4_valid_reg;
    nrrd_recip_t        s4_word_reg;
    nrrd_recip_t        s4_word_next;
    logic signed [30:0] xe_prod;
    logic signed [31:0] xe_round;

    always_comb
    begin
        xe_prod  = $signed({1'b0, s3_x_reg}) * s3_e_reg;
        xe_round = $signed({xe_prod[30], xe_prod}) + 32'sd128;

        s4_word_next.ovf   = s3_ovf_reg;
        s4_word_next.num   = s3_num_reg;
        s4_word_next.recip = xe_round[31:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_ovf_reg  <= in_word.ovf;
        s2_num_reg  <= in_word.num;
        s2_div_reg  <= in_word.divisor;
        s2_x_reg    <= s2_x_next;
        s3_ovf_reg  <= s2_ovf_reg;
        s3_num_reg  <= s2_num_reg;
        s3_x_reg    <= s2_x_reg;
        s3_e_reg    <= s3_e_next;
        s4_word_reg <= s4_word_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_word  = s4_word_reg;

endmodule

FILE: rtl/nrrd_mult.sv
// ----------------------------------------------------------------------------
// Quotient multiplier
// Multiplies the normalised numerator by the reciprocal, then rounds and
// clamps the product into the registered result word.
// ----------------------------------------------------------------------------
module nrrd_mult
    import nrrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  nrrd_recip_t in_word,
    output logic        done,
    output logic [16:0] quotient,
    output logic        overflow
);

    logic        s5_valid_reg;
    logic        s5_ovf_reg;
    logic [40:0] s5_prod_reg;
    logic [40:0] s5_prod_next;

    logic        done_reg;
    logic [16:0] quot_reg;
    logic [16:0] quot_next;
    logic        ovf_reg;
    logic [41:0] rounded;
    logic [25:0] scaled;

    always_comb
    begin
        s5_prod_next = {24'd0, in_word.num} * {17'd0, in_word.recip};
    end

    always_comb
    begin
        rounded = {1'b0, s5_prod_reg} + 42'h8000;
        scaled  = rounded[41:16];
        if (s5_ovf_reg || (scaled > {9'd0, QUOT_MAX}))
        begin
            quot_next = QUOT_MAX;
        end
        else
        begin
            quot_next = scaled[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= in_valid;
            done_reg     <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_ovf_reg  <= in_word.ovf;
        s5_prod_reg <= s5_prod_next;
        quot_reg    <= quot_next;
        ovf_reg     <= s5_ovf_reg;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
    assign overflow = ovf_reg;

endmodule

FILE: rtl/newton_raphson_reciprocal_divider_top.sv
// A word accepted with start passes the normalisation, seed, correction,
// reciprocal, product and result registers and is then on the result ports, marked by done.
// Throughput: one word per cycle; busy is always low as every stage advances
// each cycle and the result side never stalls.
// Reset: rst_n clears only the stage valid bits, so no result is signalled
// until a new word has travelled the six pipeline stages.
// ----------------------------------------------------------------------------
// Newton-Raphson reciprocal divider
// Six-stage pipeline: normalisation, seed lookup, correction, reciprocal,
// quotient product and rounding with clamp.
// ----------------------------------------------------------------------------
module newton_raphson_reciprocal_divider_top
    import nrrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] numerator,
    input  logic [15:0] denominator,
    output logic        done,
    output logic [16:0] quotient,
    output logic        overflow
);

    logic        norm_valid;
    nrrd_norm_t  norm_word;
    logic        recip_valid;
    nrrd_recip_t recip_word;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    nrrd_norm u_norm (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .numerator   (numerator),
        .denominator (denominator),
        .out_valid   (norm_valid),
        .out_word    (norm_word)
    );

    nrrd_refine u_refine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_word   (norm_word),
        .out_valid (recip_valid),
        .out_word  (recip_word)
    );

    nrrd_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (recip_valid),
        .in_word  (recip_word),
        .done     (done),
        .quotient (quotient),
        .overflow (overflow)
    );

    a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("accepted word did not produce a result");

    a_no_spurious_result : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##6 !done)
        else $error("result produced without an accepted word");

    a_zero_divisor_overflows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (denominator == 16'd0)) |-> ##6 (done && overflow))
        else $error("zero divisor did not flag overflow");

    a_overflow_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (quotient == QUOT_MAX))
        else $error("overflow result is not saturated");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Newton-Raphson reciprocal divider testbench
// Drives operand words into the divider with random gaps and checks every
// quotient and overflow flag against a predicted value, in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
    import nrrd_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_WORDS = 850;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [16:0] quotient;
        logic        overflow;
    } division_word_t;

    class division_scoreboard;
        division_word_t pending_quotients[$];
        int             error_count;

        function new();
            error_count = 0;
        endfunction

        static function int unsigned seed_entry(int unsigned n);
            int v;
            if (n >= 256)
                return 0;
            v = int'((32'h40000 / (n + 32'h100) + 1) / 2) - int'(32'h101);
            return (v < 0) ? 0 : v;
        endfunction

        static function division_word_t predict_division(logic [15:0] n, logic [15:0] d);
            division_word_t     w;
            int unsigned        shift;
            int unsigned        idx;
            logic [16:0]        num_norm;
            logic [15:0]        divisor;
            longint             x;
            longint             corr;
            longint             r;
            longint unsigned    recip;
            longint unsigned    prod;
            if (32'(d) * 2 <= 32'(n))
            begin
                w.quotient = QUOT_MAX;
                w.overflow = 1'b1;
                return w;
            end
            shift = 0;
            while (shift < 16 && d[15 - shift] == 1'b0)
                shift++;
            num_norm = 17'(n) << shift;
            divisor  = (d << shift) | 16'h8000;
            idx      = (int'(divisor & 16'h7fff) + 32'h40) >> 7;
            x        = longint'(32'h101) + longint'(seed_entry(idx));
            corr     = (longint'(128) - longint'(divisor) * x) >>> 8;
            r        = x * (longint'(32'h20000) + corr) + longint'(128);
            recip    = (unsigned'(r) & 64'hffff_ffff) >> 8;
            prod     = ((64'(num_norm) * recip + 64'h8000) >> 16) & 64'hffff_ffff;
            if (prod > 64'(QUOT_MAX))
                prod = 64'(QUOT_MAX);
            w.quotient = prod[16:0];
            w.overflow = 1'b0;
            return w;
        endfunction

        function void note_operands(logic [15:0] n, logic [15:0] d);
            pending_quotients.push_back(predict_division(n, d));
        endfunction

        function void check_word(logic [16:0] q, logic ovf);
            division_word_t w;
            if (pending_quotients.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word: quotient %h overflow %b", q, ovf);
                return;
            end
            w = pending_quotients.pop_front();
            if (w.quotient !== q || w.overflow !== ovf)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch: expected quotient %h overflow %b, got %h %b",
                             w.quotient, w.overflow, q, ovf);
            end
        endfunction

        function int outstanding();
            return pending_quotients.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] numerator;
    logic [15:0] denominator;
    logic        done;
    logic [16:0] quotient;
    logic        overflow;

    division_scoreboard sb;
    int                 stall_count = 0;

    newton_raphson_reciprocal_divider_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .numerator   (numerator),
        .denominator (denominator),
        .done        (done),
        .quotient    (quotient),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_operands(numerator, denominator);
        if (rst_n && done)
            sb.check_word(quotient, overflow);
        if ((rst_n && start && !busy) || (rst_n && done))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    initial
    begin
        wait (stall_count >= STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    task automatic send_word(input logic [15:0] n, input logic [15:0] d);
        @(negedge clk);
        start       <= 1'b1;
        numerator   <= n;
        denominator <= d;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start       <= 1'b0;
            numerator   <= 16'($urandom);
            denominator <= 16'($urandom);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic pick_operands(output logic [15:0] n, output logic [15:0] d);
        int          kind;
        int unsigned width;
        int          offset;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            n = 16'($urandom);
            d = 16'($urandom);
        end
        else if (kind < 6)
        begin
            d      = 16'($urandom_range(1, 32'h7fff));
            offset = int'($urandom_range(0, 4)) - 3;
            n      = 16'(int'(d) * 2 + offset);
        end
        else if (kind < 8)
        begin
            width = $urandom_range(1, 16);
            d     = 16'($urandom) & 16'((32'h1 << width) - 1);
            if (d == 16'h0)
                d = 16'h1;
            n     = 16'($urandom_range(0, (32'(d) * 2 > 32'hffff) ? 32'hffff : 32'(d) * 2 - 1));
        end
        else if (kind == 8)
        begin
            d = 16'($urandom_range(32'hffa0, 32'hffff));
            n = 16'($urandom);
        end
        else
        begin
            d = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hffff;
            n = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom);
        end
    endtask

    initial
    begin
        logic [15:0] n;
        logic [15:0] d;
        logic [15:0] directed_num[$];
        logic [15:0] directed_den[$];
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        numerator   = 16'h0;
        denominator = 16'h0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        directed_num = '{16'h0000, 16'hffff, 16'h0000, 16'h0001, 16'hffff, 16'h0001,
                         16'h0002, 16'hffff, 16'hfffe, 16'h0000, 16'h7fff, 16'hffff,
                         16'hfffe, 16'h1234, 16'h0003, 16'h0005, 16'hffff, 16'h8000,
                         16'h4000, 16'hfffd, 16'hff80, 16'h0001, 16'haaaa, 16'h5555};
        directed_den = '{16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'hffff, 16'h0002,
                         16'h0001, 16'h8000, 16'h7fff, 16'h8000, 16'h4000, 16'hffc0,
                         16'hffbf, 16'h091a, 16'h0002, 16'h0003, 16'h8001, 16'h4000,
                         16'h4001, 16'h7fff, 16'hffc1, 16'hffff, 16'h5556, 16'h2aab};
        foreach (directed_num[i])
        begin
            send_word(directed_num[i], directed_den[i]);
            if ($urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 17));
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick_operands(n, d);
            send_word(n, d);
            if (i == RANDOM_WORDS / 2)
                drain_results();
            if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 17));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/nrrd_pkg.sv
rtl/nrrd_norm.sv
rtl/nrrd_refine.sv
rtl/nrrd_mult.sv
rtl/newton_raphson_reciprocal_divider_top.sv
bench/testbench.sv
